// ===== rtl/core/hbpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall BLDC commutator package
// Shared widths, register map, mode codes and sector helpers.
// ----------------------------------------------------------------------------
package hbpc_pkg;

  localparam int SIXTY_DEG     = 10923;
  localparam int AMP_FRAC_BITS = 15;

  localparam int SECTOR_W = 3;
  localparam int DATA_W   = 16;
  localparam int CFG_W    = 15;
  localparam int MODE_W   = 2;
  localparam int PROD_W   = DATA_W + 1 + CFG_W;
  localparam int CLAMP_W  = CFG_W + 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 6 * DATA_W;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  localparam logic [DATA_W-1:0] HALF_TURN = 16'h8000;

  localparam logic [1:0] REG_DRIVE_MODE      = 2'd0;
  localparam logic [1:0] REG_HALF_PWM_PERIOD = 2'd1;
  localparam logic [1:0] REG_SHORT_PULSE     = 2'd2;
  localparam logic [1:0] REG_STALL_TICKS     = 2'd3;

  localparam logic [MODE_W-1:0] MODE_CLOSED_LOOP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VF_OPEN     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ANGLE_OPEN  = 2'd2;

  localparam logic [CFG_W-1:0] RST_HALF_PWM_PERIOD = 15'd1000;
  localparam logic [CFG_W-1:0] RST_SHORT_PULSE     = 15'd20;
  localparam logic [CFG_W-1:0] RST_STALL_TICKS     = 15'd1000;

  localparam logic [SECTOR_W-1:0] LAST_SECTOR = 3'd5;

  function automatic logic [SECTOR_W-1:0] sector_succ(input logic [SECTOR_W-1:0] s);
    logic [SECTOR_W-1:0] r;
    r = (s == LAST_SECTOR) ? '0 : s + 1'b1;
    return r;
  endfunction

  function automatic logic [SECTOR_W-1:0] sector_pred(input logic [SECTOR_W-1:0] s);
    logic [SECTOR_W-1:0] r;
    r = (s == '0) ? LAST_SECTOR : s - 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/core/hbpc_serial_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial constant-dividend divider
// Restoring division of a fixed dividend by an unsigned divisor, one quotient
// bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module hbpc_serial_div
  import hbpc_pkg::*;
#(
  parameter int DIVIDEND = SIXTY_DEG
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [CFG_W-1:0]                     divisor,
  output logic                                 busy,
  output logic [$clog2(DIVIDEND + 1)-1:0]      quotient
);

  localparam int QW = $clog2(DIVIDEND + 1);
  localparam int CW = $clog2(QW + 1);
  localparam logic [QW-1:0] DIVIDEND_BITS = QW'(DIVIDEND);

  logic [CFG_W-1:0] rem;
  logic [CFG_W-1:0] dvs;
  logic [QW-1:0]    quo;
  logic [CW-1:0]    cnt;
  logic [CFG_W:0]   partial;
  logic             fits;

  always_comb begin
    partial = {rem, quo[QW-1]};
    fits    = partial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(QW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= DIVIDEND_BITS;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= fits ? CFG_W'(partial - {1'b0, dvs}) : CFG_W'(partial);
      quo <= QW'({quo, fits});
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

endmodule

// ===== rtl/core/hbpc_serial_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial signed-by-unsigned multiplier
// Shift-and-add multiplier that consumes one multiplier bit per cycle and
// shifts the product out through the low half of the accumulator.
// ----------------------------------------------------------------------------
module hbpc_serial_mul
  import hbpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] multiplicand,
  input  logic [CFG_W-1:0]         multiplier,
  output logic                     busy,
  output logic signed [PROD_W-1:0] product
);

  localparam int CW = $clog2(CFG_W + 1);

  logic signed [DATA_W:0]   hi;
  logic [CFG_W-1:0]         lo;
  logic signed [DATA_W-1:0] mcand;
  logic [CW-1:0]            cnt;
  logic signed [DATA_W:0]   sum;

  always_comb begin
    sum = hi + (lo[0] ? {mcand[DATA_W-1], mcand} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(CFG_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= multiplier;
      mcand <= multiplicand;
    end else if (cnt != '0) begin
      hi <= {sum[DATA_W], sum[DATA_W:1]};
      lo <= {sum[0], lo[CFG_W-1:1]};
    end
  end

  assign busy    = (cnt != '0);
  assign product = {hi, lo};

endmodule

// ===== rtl/core/hall_bldc_position_commutator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall BLDC position commutator
// Tracks the Hall sector of one motor per modulator tick, estimates speed and
// interpolated rotor angle, and produces six-step compare values.
//
//   Channel   Direction  Content
//   s_axis    in         hall_sector, commanded_speed, amplitude
//   m_axis    out        angle, speed, edge period, compares U, V, W
//   apb       in/out     drive_mode, half_pwm_period, short_pulse, stall_ticks
//
// Each beat passes from acceptance to result through the serial multiplier
// (one bit of half_pwm_period per cycle, the divider finishing first), a state
// that sees both units idle, a clamp state and an output load state. The next
// beat is accepted in the cycle after the load at the earliest, so no beat is
// taken before the last is through. The result waits in an output register; a
// second result holds the block until the first is taken. Reset is synchronous.
// ----------------------------------------------------------------------------
module hall_bldc_position_commutator
  import hbpc_pkg::*;
#(
  parameter int SIXTY_DEGREES = SIXTY_DEG
) (
  input  logic                   clk,
  input  logic                   rst,
  // hall_sector [2:0], commanded_speed [18:3], amplitude [34:19]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // rotor_angle [15:0], rotor_speed [31:16], edge_period [47:32],
  // compare_u [63:48], compare_v [79:64], compare_w [95:80]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int QW         = $clog2(SIXTY_DEGREES + 1);
  localparam int HALF_SIXTY = SIXTY_DEGREES / 2;
  localparam logic [DATA_W-1:0] SIXTY = DATA_W'(SIXTY_DEGREES);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_CLAMP, ST_OUT} state_t;
  typedef enum logic [1:0] {SPD_CMD, SPD_ZERO, SPD_DIV, SPD_KEEP} spd_sel_t;

  state_t state;

  logic [MODE_W-1:0] drive_mode;
  logic [CFG_W-1:0]  half_pwm_period;
  logic [CFG_W-1:0]  short_pulse;
  logic [CFG_W-1:0]  stall_ticks;

  logic [SECTOR_W-1:0]     last_sector;
  logic [SECTOR_W-1:0]     expected_sector;
  logic [DATA_W-1:0]       tick_count;
  logic [DATA_W-1:0]       angle_reg;
  logic [DATA_W-1:0]       window_low;
  logic [DATA_W-1:0]       window_high;
  logic signed [DATA_W-1:0] speed_reg;
  logic signed [DATA_W-1:0] period_reg;

  logic [SECTOR_W-1:0]      j_sector;
  logic                     j_open;
  logic [DATA_W-1:0]        j_base;
  spd_sel_t                 j_sel;
  logic signed [DATA_W-1:0] j_cmd;
  logic                     j_neg;
  logic signed [CLAMP_W-1:0] q_clamped;
  logic signed [CLAMP_W-1:0] z_clamped;

  logic [SECTOR_W-1:0]      in_sector;
  logic signed [DATA_W-1:0] in_cmd;
  logic signed [DATA_W-1:0] in_amp;
  logic                     accept;
  logic                     cfg_write;
  logic                     out_load;
  logic                     open_loop;
  logic                     is_edge;
  logic                     forward;
  logic                     below_stall;
  logic                     stall_hit;
  logic [DATA_W-1:0]        stall_ext;
  logic [DATA_W-1:0]        tc1;
  logic signed [DATA_W-1:0] tc2;
  logic [DATA_W-1:0]        edge_angle;
  logic [DATA_W-1:0]        base_next;
  spd_sel_t                 sel_next;
  logic [CFG_W-1:0]         divisor;

  logic                     div_busy;
  logic [QW-1:0]            quotient;
  logic                     mul_busy;
  logic signed [PROD_W-1:0] product;

  logic signed [DATA_W-1:0]  speed_next;
  logic [DATA_W-1:0]         angle_sum;
  logic [DATA_W-1:0]         angle_next;
  logic signed [PROD_W-1:0]  q_shift;
  logic signed [PROD_W-1:0]  lim_lo;
  logic signed [PROD_W-1:0]  lim_hi;
  logic signed [CLAMP_W-1:0] q_next;
  logic signed [CLAMP_W-1:0] z_next;
  logic [DATA_W-1:0]         half16;
  logic [DATA_W-1:0]         cmp_pos;
  logic [DATA_W-1:0]         cmp_neg;
  logic [DATA_W-1:0]         cmp_zero;
  logic [DATA_W-1:0]         cmp_u;
  logic [DATA_W-1:0]         cmp_v;
  logic [DATA_W-1:0]         cmp_w;

  assign in_sector = s_tdata[2:0];
  assign in_cmd    = s_tdata[18:3];
  assign in_amp    = s_tdata[34:19];
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_load  = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    unique case (paddr[3:2])
      REG_DRIVE_MODE:      prdata = APB_DATA_W'(drive_mode);
      REG_HALF_PWM_PERIOD: prdata = APB_DATA_W'(half_pwm_period);
      REG_SHORT_PULSE:     prdata = APB_DATA_W'(short_pulse);
      REG_STALL_TICKS:     prdata = APB_DATA_W'(stall_ticks);
      default:             prdata = '0;
    endcase
  end

  // Sector edge, stall, base angle, speed source and divisor decisions for the incoming beat.
  always_comb begin
    open_loop   = (drive_mode == MODE_VF_OPEN) || (drive_mode == MODE_ANGLE_OPEN);
    is_edge     = (in_sector != last_sector);
    forward     = (in_sector == sector_succ(last_sector));
    stall_ext   = {1'b0, stall_ticks};
    below_stall = (tick_count < stall_ext);
    tc1         = (in_sector != expected_sector) ? stall_ext : tick_count;
    tc2         = forward ? $signed(tc1) : -$signed(tc1);
    stall_hit   = (tc1 == stall_ext);
    edge_angle  = DATA_W'(32'(in_sector) * 32'(SIXTY_DEGREES) - 32'(HALF_SIXTY));
    divisor     = (tc1 == '0) ? CFG_W'(1) : tc1[CFG_W-1:0];

    if (open_loop || !is_edge) begin
      base_next = angle_reg;
    end else if (forward) begin
      base_next = edge_angle;
    end else begin
      base_next = edge_angle + SIXTY;
    end

    if (open_loop) begin
      if (drive_mode == MODE_ANGLE_OPEN && !is_edge && !below_stall) begin
        sel_next = SPD_ZERO;
      end else begin
        sel_next = SPD_CMD;
      end
    end else if (is_edge) begin
      sel_next = stall_hit ? SPD_ZERO : SPD_DIV;
    end else begin
      sel_next = below_stall ? SPD_KEEP : SPD_ZERO;
    end
  end

  hbpc_serial_div #(
    .DIVIDEND (SIXTY_DEGREES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  hbpc_serial_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .multiplicand (in_amp),
    .multiplier   (half_pwm_period),
    .busy         (mul_busy),
    .product      (product)
  );

  // Speed, angle interpolation and amplitude clamp once the serial units are done.
  always_comb begin
    case (j_sel)
      SPD_CMD:  speed_next = j_cmd;
      SPD_ZERO: speed_next = '0;
      SPD_DIV:  speed_next = j_neg ? -$signed(DATA_W'(quotient)) : $signed(DATA_W'(quotient));
      default:  speed_next = speed_reg;
    endcase

    angle_sum  = j_base + speed_next;
    angle_next = angle_sum;
    if (!j_open) begin
      if (window_low < window_high) begin
        if (angle_sum < window_low) begin
          angle_next = window_low;
        end else if (angle_sum > window_high) begin
          angle_next = window_high;
        end
      end else begin
        if (angle_sum > window_high && angle_sum <= HALF_TURN) begin
          angle_next = window_high;
        end else if (angle_sum < window_low && angle_sum >= HALF_TURN) begin
          angle_next = window_low;
        end
      end
    end

    q_shift = product >>> AMP_FRAC_BITS;
    lim_lo  = PROD_W'($signed({2'b00, short_pulse}) - $signed({2'b00, half_pwm_period}));
    lim_hi  = PROD_W'($signed({2'b00, half_pwm_period}) - $signed({2'b00, short_pulse}));
    if (q_shift < lim_lo) begin
      q_next = CLAMP_W'(lim_lo);
    end else if (q_shift > lim_hi) begin
      q_next = CLAMP_W'(lim_hi);
    end else begin
      q_next = CLAMP_W'(q_shift);
    end
    if (lim_lo > 0) begin
      z_next = CLAMP_W'(lim_lo);
    end else if (lim_hi < 0) begin
      z_next = CLAMP_W'(lim_hi);
    end else begin
      z_next = '0;
    end
  end

  // Six-step compare mapping per sector.
  always_comb begin
    half16   = DATA_W'(half_pwm_period);
    cmp_pos  = half16 - DATA_W'(q_clamped);
    cmp_neg  = half16 + DATA_W'(q_clamped);
    cmp_zero = half16 - DATA_W'(z_clamped);
    case (j_sector)
      3'd0: begin
        cmp_u = cmp_zero; cmp_v = cmp_pos;  cmp_w = cmp_neg;
      end
      3'd1: begin
        cmp_u = cmp_neg;  cmp_v = cmp_pos;  cmp_w = cmp_zero;
      end
      3'd2: begin
        cmp_u = cmp_neg;  cmp_v = cmp_zero; cmp_w = cmp_pos;
      end
      3'd3: begin
        cmp_u = cmp_zero; cmp_v = cmp_neg;  cmp_w = cmp_pos;
      end
      3'd4: begin
        cmp_u = cmp_pos;  cmp_v = cmp_neg;  cmp_w = cmp_zero;
      end
      3'd5: begin
        cmp_u = cmp_pos;  cmp_v = cmp_zero; cmp_w = cmp_neg;
      end
      default: begin
        cmp_u = cmp_zero; cmp_v = cmp_zero; cmp_w = cmp_zero;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
      m_tdata         <= '0;
      drive_mode      <= MODE_CLOSED_LOOP;
      half_pwm_period <= RST_HALF_PWM_PERIOD;
      short_pulse     <= RST_SHORT_PULSE;
      stall_ticks     <= RST_STALL_TICKS;
      last_sector     <= '0;
      expected_sector <= '0;
      tick_count      <= '0;
      angle_reg       <= '0;
      window_low      <= '0;
      window_high     <= '0;
      speed_reg       <= '0;
      period_reg      <= '0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[3:2])
          REG_DRIVE_MODE:      drive_mode      <= pwdata[MODE_W-1:0];
          REG_HALF_PWM_PERIOD: half_pwm_period <= pwdata[CFG_W-1:0];
          REG_SHORT_PULSE:     short_pulse     <= pwdata[CFG_W-1:0];
          REG_STALL_TICKS:     stall_ticks     <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {cmp_w, cmp_v, cmp_u, period_reg, speed_reg, angle_reg};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            last_sector <= in_sector;
            if (is_edge) begin
              window_low      <= edge_angle;
              window_high     <= edge_angle + SIXTY;
              expected_sector <= tc2[DATA_W-1] ? sector_pred(in_sector)
                                               : sector_succ(in_sector);
              period_reg      <= tc2;
              tick_count      <= '0;
            end else if (below_stall) begin
              tick_count <= tick_count + 1'b1;
            end else begin
              period_reg <= $signed(stall_ext);
            end
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!div_busy && !mul_busy) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          speed_reg <= speed_next;
          angle_reg <= angle_next;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      j_sector <= in_sector;
      j_open   <= open_loop;
      j_base   <= base_next;
      j_sel    <= sel_next;
      j_cmd    <= in_cmd;
      j_neg    <= !forward && (tc1 != '0);
    end
    if (state == ST_CLAMP) begin
      q_clamped <= q_next;
      z_clamped <= z_next;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) !tick_count[DATA_W-1])
    else $error("tick count has gone negative");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !j_open && window_low < window_high)
    |-> (angle_reg >= window_low && angle_reg <= window_high))
    else $error("closed-loop angle lies outside the sector window");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_RUN && div_busy && mul_busy))
    else $error("serial units did not start on an accepted beat");
`endif

endmodule

// ===== sim/tb_hall_bldc_position_commutator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Hall BLDC position commutator
// Drives modulator ticks on the input stream and register writes on the APB
// port, predicts every result beat with a cycle-free model of the commutator
// held in a scoreboard, and compares each output beat field by field. A short
// directed walk through all sectors is followed by phases of random Hall
// sequences under different register settings and handshake pressure.
// ----------------------------------------------------------------------------
module tb_hall_bldc_position_commutator;
  import hbpc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_BEATS   = 225;

  localparam logic [0:21][SECTOR_W-1:0] DIRECTED_WALK = {
    3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5, 3'd0, 3'd5,
    3'd4, 3'd3, 3'd6, 3'd7, 3'd0, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd5
  };
  localparam logic [0:4][DATA_W-1:0] EXTREMES = {
    16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF
  };

  typedef struct packed {
    logic [DATA_W-1:0] compare_w;
    logic [DATA_W-1:0] compare_v;
    logic [DATA_W-1:0] compare_u;
    logic [DATA_W-1:0] edge_period;
    logic [DATA_W-1:0] rotor_speed;
    logic [DATA_W-1:0] rotor_angle;
  } commutation_t;

  class commutation_scoreboard;
    logic [MODE_W-1:0]   mode;
    logic [CFG_W-1:0]    half_period;
    logic [CFG_W-1:0]    pulse_margin;
    logic [CFG_W-1:0]    stall_limit;
    logic [SECTOR_W-1:0] last_hall;
    logic [SECTOR_W-1:0] next_expected;
    logic [DATA_W-1:0]   angle;
    logic [DATA_W-1:0]   win_lo;
    logic [DATA_W-1:0]   win_hi;
    int                  ticks;
    int                  speed;
    int                  period;
    commutation_t        pending_commutations[$];
    int                  mismatches;

    function new();
      mode          = MODE_CLOSED_LOOP;
      half_period   = RST_HALF_PWM_PERIOD;
      pulse_margin  = RST_SHORT_PULSE;
      stall_limit   = RST_STALL_TICKS;
      last_hall     = '0;
      next_expected = '0;
      angle         = '0;
      win_lo        = '0;
      win_hi        = '0;
      ticks         = 0;
      speed         = 0;
      period        = 0;
      mismatches    = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_DRIVE_MODE:      mode = value[MODE_W-1:0];
        REG_HALF_PWM_PERIOD: half_period = value[CFG_W-1:0];
        REG_SHORT_PULSE:     pulse_margin = value[CFG_W-1:0];
        REG_STALL_TICKS:     stall_limit = value[CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint bound(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function commutation_t commutate(logic [SECTOR_W-1:0] sector,
                                     logic signed [DATA_W-1:0] cmd,
                                     logic signed [DATA_W-1:0] amp);
      commutation_t        r;
      logic [SECTOR_W-1:0] from;
      logic [SECTOR_W-1:0] from_fwd;
      logic [DATA_W-1:0]   a;
      logic [DATA_W-1:0]   pos_cmp;
      logic [DATA_W-1:0]   neg_cmp;
      logic [DATA_W-1:0]   zero_cmp;
      bit                  open_loop;
      int                  stall_i;
      longint              hf;
      longint              lo;
      longint              hi;
      longint              q;
      open_loop = (mode == MODE_VF_OPEN) || (mode == MODE_ANGLE_OPEN);
      stall_i   = int'(stall_limit);
      if (open_loop) speed = int'(cmd);
      from      = last_hall;
      a         = angle;
      last_hall = sector;
      from_fwd  = (from == LAST_SECTOR) ? 3'd0 : from + 3'd1;

      if (sector != from) begin
        a      = 16'(sector * SIXTY_DEG - SIXTY_DEG / 2);
        win_lo = a;
        win_hi = a + 16'(SIXTY_DEG);
        if (sector != next_expected) ticks = stall_i;
        if (sector != from_fwd) begin
          ticks = -ticks;
          a     = a + 16'(SIXTY_DEG);
        end
        if (ticks < 0) begin
          next_expected = (sector == 3'd0) ? LAST_SECTOR : sector - 3'd1;
        end else begin
          next_expected = (sector == LAST_SECTOR) ? 3'd0 : sector + 3'd1;
        end
        period = ticks;
        if (!open_loop) begin
          if (ticks == stall_i || ticks == -stall_i) speed = 0;
          else speed = SIXTY_DEG / ((ticks == 0) ? 1 : ticks);
        end
        ticks = 0;
      end else if (ticks < stall_i) begin
        ticks++;
      end else begin
        period = stall_i;
        if (mode != MODE_VF_OPEN) speed = 0;
      end

      if (open_loop) begin
        angle = angle + 16'(speed);
      end else begin
        a = a + 16'(speed);
        if (win_lo < win_hi) begin
          if (a < win_lo) a = win_lo;
          else if (a > win_hi) a = win_hi;
        end else begin
          if (a > win_hi && a <= HALF_TURN) a = win_hi;
          else if (a < win_lo && a >= HALF_TURN) a = win_lo;
        end
        angle = a;
      end

      hf = longint'(half_period);
      lo = longint'(pulse_margin) - hf;
      hi = hf - longint'(pulse_margin);
      q  = bound((longint'(amp) * hf) >>> AMP_FRAC_BITS, lo, hi);
      pos_cmp  = 16'(hf - q);
      neg_cmp  = 16'(hf + q);
      zero_cmp = 16'(hf - bound(0, lo, hi));

      r.compare_u = zero_cmp;
      r.compare_v = zero_cmp;
      r.compare_w = zero_cmp;
      case (sector)
        3'd0: begin r.compare_v = pos_cmp; r.compare_w = neg_cmp; end
        3'd1: begin r.compare_v = pos_cmp; r.compare_u = neg_cmp; end
        3'd2: begin r.compare_w = pos_cmp; r.compare_u = neg_cmp; end
        3'd3: begin r.compare_w = pos_cmp; r.compare_v = neg_cmp; end
        3'd4: begin r.compare_u = pos_cmp; r.compare_v = neg_cmp; end
        3'd5: begin r.compare_u = pos_cmp; r.compare_w = neg_cmp; end
        default: ;
      endcase
      r.rotor_angle = angle;
      r.rotor_speed = 16'(speed);
      r.edge_period = 16'(period);
      return r;
    endfunction

    function void note_beat(logic [SECTOR_W-1:0] sector, logic [DATA_W-1:0] cmd,
                            logic [DATA_W-1:0] amp);
      pending_commutations.push_back(commutate(sector, cmd, amp));
    endfunction

    function string field_label(int i);
      case (i)
        0: return "rotor_angle";
        1: return "rotor_speed";
        2: return "edge_period";
        3: return "compare_u";
        4: return "compare_v";
        default: return "compare_w";
      endcase
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] got);
      logic [OUT_TDATA_W-1:0] want;
      if (pending_commutations.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_commutations.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (got[DATA_W*i +: DATA_W] !== want[DATA_W*i +: DATA_W]) begin
          $display("%0t: %s expected %h actual %h", $time, field_label(i),
                   want[DATA_W*i +: DATA_W], got[DATA_W*i +: DATA_W]);
          mismatches++;
        end
      end
    endfunction

    function int outstanding();
      return pending_commutations.size();
    endfunction
  endclass

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  // hall_sector [2:0], commanded_speed [18:3], amplitude [34:19]
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // rotor_angle [15:0], rotor_speed [31:16], edge_period [47:32],
  // compare_u [63:48], compare_v [79:64], compare_w [95:80]
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr    = '0;
  logic [APB_DATA_W-1:0]  pwdata   = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  commutation_scoreboard sb;
  int                    send_gap_pct   = 0;
  int                    recv_stall_pct = 0;
  int                    cycles         = 0;
  logic [CFG_W-1:0]      stall_cfg      = RST_STALL_TICKS;
  logic [SECTOR_W-1:0]   walk_sector    = '0;
  bit                    walk_forward   = 1'b1;

  hall_bldc_position_commutator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_beat(input logic [SECTOR_W-1:0] sector, input logic [DATA_W-1:0] cmd,
                           input logic [DATA_W-1:0] amp);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {{(IN_TDATA_W - 35){1'b0}}, amp, cmd, sector};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_beat(sector, cmd, amp);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic apply_settings(input logic [MODE_W-1:0] mode, input logic [CFG_W-1:0] half,
                                input logic [CFG_W-1:0] margin, input logic [CFG_W-1:0] stall);
    write_reg(REG_DRIVE_MODE, 32'(mode));
    write_reg(REG_HALF_PWM_PERIOD, 32'(half));
    write_reg(REG_SHORT_PULSE, 32'(margin));
    write_reg(REG_STALL_TICKS, 32'(stall));
    stall_cfg = stall;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0, 1: return EXTREMES[$urandom_range(4)];
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed Hall sequences: the sector dwells for a while and then
  // steps in the current direction, with occasional reversals and jumps.
  task automatic random_run(input int count);
    int sent;
    int dwell;
    int pick;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(19) == 0 && stall_cfg <= 300) dwell = $urandom_range(stall_cfg + 3);
      else dwell = $urandom_range((stall_cfg > 18) ? 20 : stall_cfg + 2);
      for (int k = 0; k <= dwell && sent < count; k++) begin
        send_beat(walk_sector, rand_word(), rand_word());
        sent++;
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        walk_sector = SECTOR_W'($urandom_range(7));
      end else begin
        if (pick < 14) walk_forward = !walk_forward;
        if (walk_forward) begin
          walk_sector = (walk_sector >= LAST_SECTOR) ? 3'd0 : walk_sector + 3'd1;
        end else begin
          walk_sector = (walk_sector == 3'd0 || walk_sector > LAST_SECTOR) ?
                        LAST_SECTOR : walk_sector - 3'd1;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 22; i++) begin
      send_beat(DIRECTED_WALK[i], EXTREMES[(i + 2) % 5], EXTREMES[i % 5]);
    end

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: apply_settings(MODE_CLOSED_LOOP, 15'd1000, 15'd20, 15'd12);
        1: apply_settings(MODE_CLOSED_LOOP, 15'd32767, 15'd0, 15'd32767);
        2: apply_settings(MODE_VF_OPEN, 15'd1500, 15'd32767, 15'd50);
        3: apply_settings(MODE_ANGLE_OPEN, CFG_W'($urandom_range(1, 32767)),
                          CFG_W'($urandom_range(200)), 15'd6);
        4: apply_settings(MODE_SPARE, 15'd1000, 15'd20, 15'd8);
        5: apply_settings(MODE_CLOSED_LOOP, 15'd1, 15'd1, 15'd1);
        6: apply_settings(MODE_VF_OPEN, 15'd32767, 15'd32767, 15'd1);
        default: apply_settings(MODE_ANGLE_OPEN, 15'd1, 15'd0, 15'd32767);
      endcase
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 69; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 69; end
        default: begin send_gap_pct = 36; recv_stall_pct = 36; end
      endcase
      random_run(PHASE_BEATS);
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/hbpc_pkg.sv
rtl/core/hbpc_serial_div.sv
rtl/core/hbpc_serial_mul.sv
rtl/core/hall_bldc_position_commutator.sv
sim/tb_hall_bldc_position_commutator.sv
